// ===== rtl/core/hne_pkg.sv =====
// Package for the height-map normal encoder: widths, codes, reset values
// and the structs passed between the square-root and encoder cells.
// No dependencies.
package hne_pkg;

  localparam int HEIGHT_BITS_DEF = 20;
  localparam int GAIN_W          = 8;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 8'd50;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam logic [0:0] REG_SLOPE_GAIN = 1'b0;

  localparam int WORK_BITS = 23;
  localparam int ONE_W     = 17;
  localparam int ONE_SHIFT = 16;
  localparam int SQ_W      = 2 * WORK_BITS;
  localparam int SUM_W     = SQ_W + 1;
  localparam int ROOT_W    = 24;
  localparam int RAD_W     = 2 * ROOT_W;
  localparam int REM_W     = ROOT_W + 2;
  localparam int CZ_W      = 24;
  localparam int CZSQ_W    = 2 * CZ_W;
  localparam int LEN_W     = CZSQ_W + 1;
  localparam int K_SHIFT   = 14;
  localparam int K_W       = CZSQ_W + K_SHIFT;
  localparam int ENC_Q_W   = 8;
  localparam int ENC_CELLS = ENC_Q_W;
  localparam int P_W       = LEN_W + ENC_Q_W;
  localparam int CAND_W    = P_W + ENC_Q_W + 2;
  localparam int BYTE_W    = 8;
  localparam int OUT_W     = 3 * BYTE_W;

  typedef struct packed {
    logic                 sx;
    logic                 sy;
    logic [WORK_BITS-1:0] ax;
    logic [WORK_BITS-1:0] ay;
    logic [ONE_W-1:0]     one;
    logic [SQ_W-1:0]      axsq;
    logic [SQ_W-1:0]      aysq;
    logic [SUM_W-1:0]     sum;
  } sq_side_t;

  typedef struct packed {
    logic [RAD_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    sq_side_t          side;
  } sq_cell_t;

  typedef struct packed {
    logic [ENC_Q_W-1:0] q;
    logic [P_W-1:0]     p;
    logic [K_W-1:0]     qq;
    logic [K_W-1:0]     k;
    logic [LEN_W-1:0]   len2;
    logic               neg;
  } enc_lane_t;

  typedef enc_lane_t [2:0] enc_trio_t;

endpackage

// ===== rtl/core/hne_sqrt_cell.sv =====
// One digit of the restoring integer square root, registered.
// Depends on hne_pkg.
module hne_sqrt_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              vld_i,
  input  hne_pkg::sq_cell_t d_i,
  output logic              vld_o,
  output hne_pkg::sq_cell_t d_o
);
  import hne_pkg::*;

  logic [REM_W+1:0] rr;
  logic [REM_W+1:0] trial;
  logic             ge;
  sq_cell_t         d_nxt;
  sq_cell_t         d_r;
  logic             vld_r;

  always_comb begin
    rr    = {d_i.rem, d_i.rad[RAD_W-1 -: 2]};
    trial = (REM_W+2)'({d_i.root, 2'b01});
    ge    = (rr >= trial);
    d_nxt = d_i;
    d_nxt.rem  = ge ? REM_W'(rr - trial) : REM_W'(rr);
    d_nxt.root = {d_i.root[ROOT_W-2:0], ge};
    d_nxt.rad  = {d_i.rad[RAD_W-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign vld_o = vld_r;
  assign d_o   = d_r;

endmodule

// ===== rtl/core/hne_enc_cell.sv =====
// One bit of the byte encoder for all three components, registered.
// Depends on hne_pkg.
module hne_enc_cell #(
  parameter int BIT = 7
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               vld_i,
  input  hne_pkg::enc_trio_t d_i,
  output logic               vld_o,
  output hne_pkg::enc_trio_t d_o
);
  import hne_pkg::*;

  logic [CAND_W-1:0] cand [3];
  logic              ok   [3];
  enc_trio_t         d_nxt;
  enc_trio_t         d_r;
  logic              vld_r;

  always_comb begin
    d_nxt = d_i;
    for (int l = 0; l < 3; l++) begin
      cand[l] = CAND_W'(d_i[l].qq) + (CAND_W'(d_i[l].p) << (BIT + 1))
              + (CAND_W'(d_i[l].len2) << (2 * BIT));
      ok[l]   = d_i[l].neg ? (cand[l] < CAND_W'(d_i[l].k))
                           : (cand[l] <= CAND_W'(d_i[l].k));
      if (ok[l]) begin
        d_nxt[l].q[BIT] = 1'b1;
        d_nxt[l].p      = d_i[l].p + (P_W'(d_i[l].len2) << BIT);
        d_nxt[l].qq     = K_W'(cand[l]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign vld_o = vld_r;
  assign d_o   = d_r;

endmodule

// ===== rtl/core/heightmap_normal_encoder.sv =====
// Height-map normal encoder: forward differences, scaling, square root chain
// and byte encoder chain. Depends on hne_pkg, hne_sqrt_cell, hne_enc_cell.
// Pipeline from input transaction to out_tvalid: 4 front stages,
// 24 square-root cells, 2 z stages, 8 encoder cells, output register.
// Throughput: one transaction per cycle; the whole pipe holds while the
// output is stalled. Reset (synchronous, rst_n low) empties the pipe and
// sets slope_gain to 50.
module heightmap_normal_encoder #(
  parameter int HEIGHT_BITS = hne_pkg::HEIGHT_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // height_here, height_right, height_below (lowest bits first)
  input  logic [((3*HEIGHT_BITS+7)/8)*8-1:0]     in_tdata,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // normal_x_byte, normal_y_byte, normal_z_byte (lowest bits first)
  output logic [hne_pkg::OUT_W-1:0]              out_tdata,
  input  logic                                   cfg_psel,
  input  logic                                   cfg_penable,
  input  logic                                   cfg_pwrite,
  input  logic [hne_pkg::CFG_ADDR_W-1:0]         cfg_paddr,
  input  logic [hne_pkg::CFG_DATA_W-1:0]         cfg_pwdata,
  output logic [hne_pkg::CFG_DATA_W-1:0]         cfg_prdata,
  output logic                                   cfg_pready
);
  import hne_pkg::*;

  localparam int HB     = HEIGHT_BITS;
  localparam int DW     = HB + 1;
  localparam int EW     = HB + GAIN_W + 2;
  localparam int MW     = HB + GAIN_W;
  localparam int MXW    = (MW > WORK_BITS) ? MW : WORK_BITS;
  localparam int SH_MAX = (MW > WORK_BITS) ? MW - WORK_BITS : 0;
  localparam int SW     = (SH_MAX > 0) ? $clog2(SH_MAX + 1) : 1;

  logic en;
  logic [GAIN_W-1:0] gain_r;
  logic cfg_wr;

  logic v1_r, v2_r, v3_r, v4_r, va_r, vb_r, out_vld_r;
  logic signed [DW-1:0] dx_r, dy_r;
  logic [MW-1:0] mx_r, my_r;
  logic sx2_r, sy2_r;
  logic signed [EW-1:0] ex, ey;
  logic [MXW-1:0] mxe, mye, orv;
  logic [SW-1:0] s_c;
  logic [WORK_BITS-1:0] ax_r, ay_r;
  logic [ONE_W-1:0] one_r;
  logic sx3_r, sy3_r;
  sq_side_t side4_r;

  sq_cell_t sq_d [ROOT_W+1];
  logic     sq_v [ROOT_W+1];

  logic signed [ROOT_W:0] cz_s;
  logic [CZ_W-1:0] cz_abs_r;
  logic cz_neg_a_r, cz_neg_b_r;
  sq_side_t side_a_r, side_b_r;
  logic [CZSQ_W-1:0] czsq_r;
  logic [LEN_W-1:0] len2;

  enc_trio_t enc_d [ENC_CELLS+1];
  logic      enc_v [ENC_CELLS+1];

  logic [BYTE_W-1:0] byte_c [3];
  logic [OUT_W-1:0] out_r;

  assign en        = !out_vld_r || out_tready;
  assign in_tready = en;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite
                  && (cfg_paddr[CFG_ADDR_W-1] == REG_SLOPE_GAIN);
  assign cfg_prdata = (cfg_paddr[CFG_ADDR_W-1] == REG_SLOPE_GAIN)
                      ? CFG_DATA_W'(gain_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= GAIN_RESET;
    end else if (cfg_wr) begin
      gain_r <= cfg_pwdata[GAIN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      v3_r      <= 1'b0;
      v4_r      <= 1'b0;
      va_r      <= 1'b0;
      vb_r      <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      v1_r      <= in_tvalid;
      v2_r      <= v1_r;
      v3_r      <= v2_r;
      v4_r      <= v3_r;
      va_r      <= sq_v[ROOT_W];
      vb_r      <= va_r;
      out_vld_r <= enc_v[ENC_CELLS];
    end
  end

  always_comb begin
    ex  = EW'(dx_r) * $signed({2'b00, gain_r});
    ey  = EW'(dy_r) * $signed({2'b00, gain_r});
    mxe = MXW'(mx_r);
    mye = MXW'(my_r);
    orv = mxe | mye;
    s_c = '0;
    for (int i = SH_MAX; i >= 0; i--) begin
      if (((orv >> i) >> WORK_BITS) == '0) begin
        s_c = SW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r <= DW'($signed(in_tdata[2*HB-1:HB])) - DW'($signed(in_tdata[HB-1:0]));
      dy_r <= DW'($signed(in_tdata[3*HB-1:2*HB])) - DW'($signed(in_tdata[HB-1:0]));
      sx2_r <= ex[EW-1];
      sy2_r <= ey[EW-1];
      mx_r  <= ex[EW-1] ? MW'(-ex) : MW'(ex);
      my_r  <= ey[EW-1] ? MW'(-ey) : MW'(ey);
      ax_r  <= WORK_BITS'(mxe >> s_c);
      ay_r  <= WORK_BITS'(mye >> s_c);
      one_r <= (32'(s_c) <= ONE_SHIFT) ? ONE_W'((32'd1 << ONE_SHIFT) >> s_c) : '0;
      sx3_r <= sx2_r;
      sy3_r <= sy2_r;
      side4_r.sx   <= sx3_r;
      side4_r.sy   <= sy3_r;
      side4_r.ax   <= ax_r;
      side4_r.ay   <= ay_r;
      side4_r.one  <= one_r;
      side4_r.axsq <= SQ_W'(ax_r) * SQ_W'(ax_r);
      side4_r.aysq <= SQ_W'(ay_r) * SQ_W'(ay_r);
      side4_r.sum  <= '0;
    end
  end

  always_comb begin
    sq_d[0]          = '0;
    sq_d[0].side     = side4_r;
    sq_d[0].side.sum = SUM_W'(side4_r.axsq) + SUM_W'(side4_r.aysq);
    sq_d[0].rad      = RAD_W'(sq_d[0].side.sum);
    sq_v[0]          = v4_r;
  end

  for (genvar i = 0; i < ROOT_W; i++) begin : g_sqrt
    hne_sqrt_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .vld_i (sq_v[i]),
      .d_i   (sq_d[i]),
      .vld_o (sq_v[i+1]),
      .d_o   (sq_d[i+1])
    );
  end

  assign cz_s = $signed((ROOT_W+1)'(sq_d[ROOT_W].side.one))
              - $signed({1'b0, sq_d[ROOT_W].root});

  always_ff @(posedge clk) begin
    if (en) begin
      cz_abs_r   <= cz_s[ROOT_W] ? CZ_W'(-cz_s) : CZ_W'(cz_s);
      cz_neg_a_r <= cz_s[ROOT_W];
      side_a_r   <= sq_d[ROOT_W].side;
      czsq_r     <= CZSQ_W'(cz_abs_r) * CZSQ_W'(cz_abs_r);
      cz_neg_b_r <= cz_neg_a_r;
      side_b_r   <= side_a_r;
    end
  end

  always_comb begin
    len2     = LEN_W'(side_b_r.sum) + LEN_W'(czsq_r);
    enc_d[0] = '0;
    for (int l = 0; l < 3; l++) begin
      enc_d[0][l].len2 = len2;
    end
    enc_d[0][0].k   = K_W'(side_b_r.axsq) << K_SHIFT;
    enc_d[0][0].neg = side_b_r.sx && (side_b_r.ax != '0);
    enc_d[0][1].k   = K_W'(side_b_r.aysq) << K_SHIFT;
    enc_d[0][1].neg = side_b_r.sy && (side_b_r.ay != '0);
    enc_d[0][2].k   = K_W'(czsq_r) << K_SHIFT;
    enc_d[0][2].neg = cz_neg_b_r;
    enc_v[0]        = vb_r;
  end

  for (genvar i = 0; i < ENC_CELLS; i++) begin : g_enc
    hne_enc_cell #(.BIT(ENC_Q_W - 1 - i)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .vld_i (enc_v[i]),
      .d_i   (enc_d[i]),
      .vld_o (enc_v[i+1]),
      .d_o   (enc_d[i+1])
    );
  end

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if (enc_d[ENC_CELLS][l].neg) begin
        byte_c[l] = BYTE_W'(8'd127 - enc_d[ENC_CELLS][l].q);
      end else if (enc_d[ENC_CELLS][l].q[ENC_Q_W-1]) begin
        byte_c[l] = 8'd255;
      end else begin
        byte_c[l] = BYTE_W'(8'd128 + enc_d[ENC_CELLS][l].q);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= {byte_c[2], byte_c[1], byte_c[0]};
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_r;

endmodule

// ===== rtl/core/hne_checker.sv =====
// Port-level checks for the height-map normal encoder, bound to the top.
// Depends on hne_pkg and heightmap_normal_encoder.
module hne_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [hne_pkg::OUT_W-1:0]      out_tdata,
  input logic                           cfg_psel,
  input logic                           cfg_penable,
  input logic                           cfg_pwrite,
  input logic [hne_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input logic [hne_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  input logic [hne_pkg::CFG_DATA_W-1:0] cfg_prdata
);
  import hne_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled output transaction changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready does not follow output stall");

  a_cfg_rb: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr[CFG_ADDR_W-1] == REG_SLOPE_GAIN)
    |=> (cfg_paddr[CFG_ADDR_W-1] != REG_SLOPE_GAIN)
        || (cfg_prdata[7:0] == $past(cfg_pwdata[7:0])))
    else $error("slope gain read-back mismatch");

endmodule

bind heightmap_normal_encoder hne_checker u_hne_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_tready   (in_tready),
  .out_tvalid  (out_tvalid),
  .out_tready  (out_tready),
  .out_tdata   (out_tdata),
  .cfg_psel    (cfg_psel),
  .cfg_penable (cfg_penable),
  .cfg_pwrite  (cfg_pwrite),
  .cfg_paddr   (cfg_paddr),
  .cfg_pwdata  (cfg_pwdata),
  .cfg_prdata  (cfg_prdata)
);
